/* hw/rtl/uecu_pkg.sv */
// Shared constants, micro-op types and the per-cell micro-program for the
// upwind Euler cell update. No dependencies.
package uecu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;
  localparam int ACC_BITS  = 64;
  localparam int HALF_BITS = ACC_BITS / 2;
  localparam int DIV_BITS  = ACC_BITS + FRAC_BITS;
  localparam int DCNT_BITS = $clog2(DIV_BITS);
  localparam int PROD_BITS = 2 * ACC_BITS - FRAC_BITS + 1;
  localparam int PROG_LEN  = 47;
  localparam int PC_BITS   = $clog2(PROG_LEN);
  localparam int TMP_DEPTH = 16;
  localparam int TMP_BITS  = $clog2(TMP_DEPTH);

  localparam int NU_BITS   = 25;
  localparam int GM1_BITS  = 25;
  localparam int IGM1_BITS = 31;
  localparam int GR_BITS   = 31;
  localparam int CFG_DATA  = 32;
  localparam int CFG_ADDR  = 4;

  localparam logic [NU_BITS-1:0]   NU_RESET   = NU_BITS'(6710886);
  localparam logic [GM1_BITS-1:0]  GM1_RESET  = GM1_BITS'(6710886);
  localparam logic [IGM1_BITS-1:0] IGM1_RESET = IGM1_BITS'(41943040);
  localparam logic [GR_BITS-1:0]   GR_RESET   = GR_BITS'(58720256);

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_COURANT = 2'd0;
  localparam logic [1:0] REG_GM1     = 2'd1;
  localparam logic [1:0] REG_IGM1    = 2'd2;
  localparam logic [1:0] REG_GRATIO  = 2'd3;

  // Word-range limits held in accumulator width
  localparam logic signed [ACC_BITS-1:0] W_MAX =
    ACC_BITS'((65'd1 << (WORD_BITS - 1)) - 65'd1);
  localparam logic signed [ACC_BITS-1:0] W_MIN = -W_MAX - ACC_BITS'(1);
  localparam logic signed [ACC_BITS-1:0] A_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] A_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_HALF, OP_WSAT, OP_SEL, OP_DIV
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] dst;
    logic [4:0] a;
    logic [4:0] b;
  } uop_t;

  // Operand codes: scratch entries, then named sources (bit 4 set)
  localparam logic [4:0] T0 = 5'd0, T1 = 5'd1, T2 = 5'd2, T3 = 5'd3;
  localparam logic [4:0] T4 = 5'd4, T5 = 5'd5, T6 = 5'd6, T7 = 5'd7;
  localparam logic [4:0] T8 = 5'd8, T9 = 5'd9, T10 = 5'd10, T11 = 5'd11;
  localparam logic [4:0] R_RN = 5'd12, R_UN = 5'd13, R_PN = 5'd14;
  localparam logic [4:0] SRC_RL = 5'd16, SRC_UL = 5'd17, SRC_PL = 5'd18;
  localparam logic [4:0] SRC_RC = 5'd19, SRC_UC = 5'd20, SRC_PC = 5'd21;
  localparam logic [4:0] SRC_RR = 5'd22, SRC_UR = 5'd23, SRC_PR = 5'd24;
  localparam logic [4:0] SRC_NU = 5'd25, SRC_GM1 = 5'd26;
  localparam logic [4:0] SRC_IGM1 = 5'd27, SRC_GR = 5'd28;

  // One cell update: fluxes, upwind differences, new density, velocity, pressure
  function automatic uop_t prog_entry(logic [PC_BITS-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = '{OP_MUL,  T0,   SRC_RL, SRC_UL};
      6'd1:  u = '{OP_MUL,  T1,   SRC_RC, SRC_UC};
      6'd2:  u = '{OP_MUL,  T2,   SRC_RR, SRC_UR};
      6'd3:  u = '{OP_MUL,  T3,   T0,     SRC_UL};
      6'd4:  u = '{OP_MUL,  T4,   T1,     SRC_UC};
      6'd5:  u = '{OP_MUL,  T5,   T2,     SRC_UR};
      6'd6:  u = '{OP_HALF, T6,   T3,     T0};
      6'd7:  u = '{OP_HALF, T7,   T4,     T0};
      6'd8:  u = '{OP_HALF, T8,   T5,     T0};
      6'd9:  u = '{OP_MUL,  T9,   SRC_GR, SRC_PL};
      6'd10: u = '{OP_ADD,  T9,   T9,     T6};
      6'd11: u = '{OP_MUL,  T6,   T9,     SRC_UL};
      6'd12: u = '{OP_MUL,  T9,   SRC_GR, SRC_PC};
      6'd13: u = '{OP_ADD,  T9,   T9,     T7};
      6'd14: u = '{OP_MUL,  T10,  T9,     SRC_UC};
      6'd15: u = '{OP_MUL,  T9,   SRC_GR, SRC_PR};
      6'd16: u = '{OP_ADD,  T9,   T9,     T8};
      6'd17: u = '{OP_MUL,  T8,   T9,     SRC_UR};
      6'd18: u = '{OP_SUB,  T9,   T1,     T0};
      6'd19: u = '{OP_SUB,  T11,  T2,     T1};
      6'd20: u = '{OP_SEL,  T0,   T9,     T11};
      6'd21: u = '{OP_SUB,  T9,   T4,     T3};
      6'd22: u = '{OP_SUB,  T11,  T5,     T4};
      6'd23: u = '{OP_SEL,  T2,   T9,     T11};
      6'd24: u = '{OP_SUB,  T9,   T10,    T6};
      6'd25: u = '{OP_SUB,  T11,  T8,     T10};
      6'd26: u = '{OP_SEL,  T3,   T9,     T11};
      6'd27: u = '{OP_MUL,  T9,   SRC_NU, T0};
      6'd28: u = '{OP_SUB,  T9,   SRC_RC, T9};
      6'd29: u = '{OP_WSAT, R_RN, T9,     T0};
      6'd30: u = '{OP_MUL,  T9,   SRC_NU, T2};
      6'd31: u = '{OP_SUB,  T9,   T1,     T9};
      6'd32: u = '{OP_SUB,  T11,  SRC_PR, SRC_PL};
      6'd33: u = '{OP_MUL,  T11,  SRC_NU, T11};
      6'd34: u = '{OP_HALF, T11,  T11,    T0};
      6'd35: u = '{OP_SUB,  T9,   T9,     T11};
      6'd36: u = '{OP_DIV,  R_UN, T9,     R_RN};
      6'd37: u = '{OP_MUL,  T9,   R_RN,   R_UN};
      6'd38: u = '{OP_MUL,  T9,   T9,     R_UN};
      6'd39: u = '{OP_HALF, T9,   T9,     T0};
      6'd40: u = '{OP_MUL,  T11,  SRC_PC, SRC_IGM1};
      6'd41: u = '{OP_ADD,  T11,  T11,    T7};
      6'd42: u = '{OP_SUB,  T11,  T11,    T9};
      6'd43: u = '{OP_MUL,  T9,   SRC_NU, T3};
      6'd44: u = '{OP_SUB,  T11,  T11,    T9};
      6'd45: u = '{OP_MUL,  T11,  SRC_GM1, T11};
      6'd46: u = '{OP_WSAT, R_PN, T11,    T0};
      default: u = '{OP_ADD, T0, T0, T0};
    endcase
    return u;
  endfunction

endpackage

/* hw/rtl/uecu_ifs.sv */
// Valid/ready channel interfaces for grid cells in and updated cells out.
// Depends on uecu_pkg for the word width.
interface uecu_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [uecu_pkg::WORD_BITS-1:0]  rho_in;
  logic signed [uecu_pkg::WORD_BITS-1:0]  u_in;
  logic signed [uecu_pkg::WORD_BITS-1:0]  p_in;
  logic                                   cell_last;
  modport source (output valid, rho_in, u_in, p_in, cell_last, input ready);
  modport sink   (input valid, rho_in, u_in, p_in, cell_last, output ready);
endinterface

interface uecu_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [uecu_pkg::WORD_BITS-1:0]  rho_out;
  logic signed [uecu_pkg::WORD_BITS-1:0]  u_out;
  logic signed [uecu_pkg::WORD_BITS-1:0]  p_out;
  logic                                   last_out;
  logic                                   div_error;
  modport source (output valid, rho_out, u_out, p_out, last_out, div_error, input ready);
  modport sink   (input valid, rho_out, u_out, p_out, last_out, div_error, output ready);
endinterface

/* hw/rtl/upwind_euler_cell_update_top.sv */
// One upwind Euler time step over a stream of grid cells, run as a micro-program
// on a shared 32x32 multiplier, a saturating adder and a radix-2 divider.
// Depends on uecu_pkg and uecu_ifs.
//
// Use: cells (rho_in, u_in, p_in, cell_last) enter on cell_in, left to right;
// updated cells leave on cell_out. Registers (nu, gamma-1, 1/(gamma-1),
// gamma/(gamma-1)) sit on the APB port at byte addresses 0, 4, 8, 12.
// The first two cells of a sweep give no beat. The third gives the left
// boundary cell and cell 1, each later cell one interior cell, and the last
// cell adds the right boundary cell. A right boundary that does not fit is
// held and sent first while the next cell is processed.
// Flow: cell_in is ready only while the block is idle. A cell that completes
// a window runs 47 micro-ops: 20 multiplies (a partial-product loop on the one
// multiplier), 26 add/select ops and one division (fetch, setup, 88 quotient-bit
// steps, clamp and write-back), then sends its output beats and shifts the
// window. A cell that only fills the window is just shifted in.
// Output beats are shown from held registers and wait as long as cell_out
// stalls. Reset empties the window, drops any held boundary cell and loads
// the register defaults.
module upwind_euler_cell_update_top (
  input  logic                              clk,
  input  logic                              rst,
  uecu_in_if.sink                           cell_in,
  uecu_out_if.source                        cell_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [uecu_pkg::CFG_ADDR-1:0]     paddr,
  input  logic [uecu_pkg::CFG_DATA-1:0]     pwdata,
  output logic [uecu_pkg::CFG_DATA-1:0]     prdata,
  output logic                              pready
);

  localparam int W = uecu_pkg::WORD_BITS;
  localparam int A = uecu_pkg::ACC_BITS;
  localparam int H = uecu_pkg::HALF_BITS;
  localparam int F = uecu_pkg::FRAC_BITS;
  localparam int D = uecu_pkg::DIV_BITS;
  localparam int P = uecu_pkg::PROD_BITS;
  localparam int CFG_DATA_W = uecu_pkg::CFG_DATA;

  typedef enum logic [3:0] {
    S_IDLE, S_PEND, S_READ, S_EXEC, S_MUL, S_MULF, S_DIV, S_DIVF, S_WB,
    S_LB, S_MID, S_RB, S_WIN
  } state_t;

  state_t state;

  // Configuration
  logic [uecu_pkg::NU_BITS-1:0]   nu;
  logic [uecu_pkg::GM1_BITS-1:0]  gm1;
  logic [uecu_pkg::IGM1_BITS-1:0] igm1;
  logic [uecu_pkg::GR_BITS-1:0]   gratio;

  // Window and cell state
  logic signed [W-1:0] win_rho [2];
  logic signed [W-1:0] win_u   [2];
  logic signed [W-1:0] win_p   [2];
  logic [1:0]          cells_seen;
  logic signed [W-1:0] in_rho, in_u, in_p;
  logic                in_last;
  logic                pend_valid, had_pend;
  logic signed [W-1:0] pend_rho, pend_p;
  logic signed [W-1:0] rn, un, pn;
  logic                err;

  // Sequencer and datapath
  logic [uecu_pkg::PC_BITS-1:0] pc;
  uecu_pkg::uop_t               cur;
  logic signed [A-1:0]          tmp_mem [uecu_pkg::TMP_DEPTH];
  logic signed [A-1:0]          opa, opb, res, alu_res, named_a, named_b;
  logic [A-1:0]                 mx, my;
  logic                         mneg;
  logic [2:0]                   mcnt;
  logic [1:0]                   mk;
  logic [H-1:0]                 xs, ys;
  logic [A-1:0]                 pp, prod;
  logic [2*A-1:0]               acc;
  logic [P-1:0]                 qr;
  logic signed [A-1:0]          mulf_res;
  logic [D-1:0]                 dvd, quo;
  logic [A-1:0]                 dden, rem;
  logic [A:0]                   rem2;
  logic                         ge, dneg;
  logic [uecu_pkg::DCNT_BITS-1:0] dcnt;
  logic signed [A-1:0]          divf_res;
  logic                         cfg_wr;

  assign cur = uecu_pkg::prog_entry(pc);

  function automatic logic signed [A-1:0] sext(logic signed [W-1:0] v);
    return {{(A-W){v[W-1]}}, v};
  endfunction

  function automatic logic [A-1:0] mag(logic signed [A-1:0] v);
    return v[A-1] ? A'(-v) : A'(v);
  endfunction

  function automatic logic signed [A-1:0] sat65(logic signed [A:0] s);
    logic signed [A-1:0] r;
    if (s[A] != s[A-1]) r = s[A] ? uecu_pkg::A_MIN : uecu_pkg::A_MAX;
    else r = s[A-1:0];
    return r;
  endfunction

  function automatic logic signed [A-1:0] wsat(logic signed [A-1:0] v);
    logic signed [A-1:0] r;
    if (v > uecu_pkg::W_MAX) r = uecu_pkg::W_MAX;
    else if (v < uecu_pkg::W_MIN) r = uecu_pkg::W_MIN;
    else r = v;
    return r;
  endfunction

  function automatic logic signed [A-1:0] named_src(
    logic [3:0] sel, logic signed [W-1:0] rl, logic signed [W-1:0] ul,
    logic signed [W-1:0] pl, logic signed [W-1:0] rc, logic signed [W-1:0] uc,
    logic signed [W-1:0] pcc, logic signed [W-1:0] rr, logic signed [W-1:0] ur,
    logic signed [W-1:0] pr, logic [A-1:0] c_nu, logic [A-1:0] c_gm1,
    logic [A-1:0] c_igm1, logic [A-1:0] c_gr);
    logic signed [A-1:0] r;
    unique case ({1'b1, sel})
      uecu_pkg::SRC_RL:   r = sext(rl);
      uecu_pkg::SRC_UL:   r = sext(ul);
      uecu_pkg::SRC_PL:   r = sext(pl);
      uecu_pkg::SRC_RC:   r = sext(rc);
      uecu_pkg::SRC_UC:   r = sext(uc);
      uecu_pkg::SRC_PC:   r = sext(pcc);
      uecu_pkg::SRC_RR:   r = sext(rr);
      uecu_pkg::SRC_UR:   r = sext(ur);
      uecu_pkg::SRC_PR:   r = sext(pr);
      uecu_pkg::SRC_NU:   r = c_nu;
      uecu_pkg::SRC_GM1:  r = c_gm1;
      uecu_pkg::SRC_IGM1: r = c_igm1;
      uecu_pkg::SRC_GR:   r = c_gr;
      default:            r = '0;
    endcase
    return r;
  endfunction

  // Named operand fetch: window, current cell, registers
  always_comb begin
    named_a = named_src(cur.a[3:0], win_rho[0], win_u[0], win_p[0], win_rho[1],
                        win_u[1], win_p[1], in_rho, in_u, in_p, A'(nu), A'(gm1),
                        A'(igm1), A'(gratio));
    named_b = named_src(cur.b[3:0], win_rho[0], win_u[0], win_p[0], win_rho[1],
                        win_u[1], win_p[1], in_rho, in_u, in_p, A'(nu), A'(gm1),
                        A'(igm1), A'(gratio));
  end

  // Combinational ALU ops
  always_comb begin
    unique case (cur.op)
      uecu_pkg::OP_ADD:  alu_res = sat65({opa[A-1], opa} + {opb[A-1], opb});
      uecu_pkg::OP_SUB:  alu_res = sat65({opa[A-1], opa} - {opb[A-1], opb});
      uecu_pkg::OP_HALF: alu_res = $signed(opa + A'(opa[A-1])) >>> 1;
      uecu_pkg::OP_WSAT: alu_res = wsat(opa);
      uecu_pkg::OP_SEL:  alu_res = (win_u[1] > 0) ? opa : opb;
      default:           alu_res = opa;
    endcase
  end

  // Multiplier: one 32x32 partial product per cycle
  assign mk   = 2'(mcnt - 3'd1);
  assign xs   = mcnt[0] ? mx[A-1:H] : mx[H-1:0];
  assign ys   = mcnt[1] ? my[A-1:H] : my[H-1:0];
  assign prod = xs * ys;

  // Floor to the fraction width, then saturate with sign
  always_comb begin
    qr = P'(acc[2*A-1:F]) + P'(mneg & (|acc[F-1:0]));
    if (mneg) mulf_res = (|qr[P-1:A-1]) ? uecu_pkg::A_MIN : -$signed(qr[A-1:0]);
    else      mulf_res = (|qr[P-1:A-1]) ? uecu_pkg::A_MAX : $signed(qr[A-1:0]);
  end

  // Divider step and result clamp to the word range
  assign rem2 = {rem, dvd[D-1]};
  assign ge   = rem2 >= {1'b0, dden};
  always_comb begin
    if (dneg)
      divf_res = (quo > D'(uecu_pkg::W_MAX) + D'(1)) ? uecu_pkg::W_MIN
                                                    : -$signed(quo[A-1:0]);
    else
      divf_res = (quo > D'(uecu_pkg::W_MAX)) ? uecu_pkg::W_MAX : $signed(quo[A-1:0]);
  end

  // Scratch memory: operand read into registers, result write-back
  always_ff @(posedge clk) begin
    if (state == S_WB) tmp_mem[cur.dst[3:0]] <= res;
    if (state == S_READ) begin
      opa <= cur.a[4] ? named_a : tmp_mem[cur.a[3:0]];
      opb <= cur.b[4] ? named_b : tmp_mem[cur.b[3:0]];
    end
  end

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[3:2])
      uecu_pkg::REG_COURANT: prdata = CFG_DATA_W'(nu);
      uecu_pkg::REG_GM1:     prdata = CFG_DATA_W'(gm1);
      uecu_pkg::REG_IGM1:    prdata = CFG_DATA_W'(igm1);
      uecu_pkg::REG_GRATIO:  prdata = CFG_DATA_W'(gratio);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nu     <= uecu_pkg::NU_RESET;
      gm1    <= uecu_pkg::GM1_RESET;
      igm1   <= uecu_pkg::IGM1_RESET;
      gratio <= uecu_pkg::GR_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        uecu_pkg::REG_COURANT: nu     <= pwdata[uecu_pkg::NU_BITS-1:0];
        uecu_pkg::REG_GM1:     gm1    <= pwdata[uecu_pkg::GM1_BITS-1:0];
        uecu_pkg::REG_IGM1:    igm1   <= pwdata[uecu_pkg::IGM1_BITS-1:0];
        uecu_pkg::REG_GRATIO:  gratio <= pwdata[uecu_pkg::GR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Channels
  assign cell_in.ready = (state == S_IDLE);
  assign cell_out.valid = (state == S_PEND) || (state == S_LB) ||
                          (state == S_MID) || (state == S_RB);
  always_comb begin
    cell_out.rho_out   = rn;
    cell_out.u_out     = '0;
    cell_out.p_out     = pn;
    cell_out.last_out  = 1'b0;
    cell_out.div_error = 1'b0;
    unique case (state)
      S_PEND: begin
        cell_out.rho_out  = pend_rho;
        cell_out.p_out    = pend_p;
        cell_out.last_out = 1'b1;
      end
      S_MID: begin
        cell_out.u_out     = un;
        cell_out.div_error = err;
      end
      S_RB:    cell_out.last_out = 1'b1;
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cells_seen <= '0;
      pend_valid <= 1'b0;
      pc         <= '0;
      for (int i = 0; i < 2; i++) begin
        win_rho[i] <= '0;
        win_u[i]   <= '0;
        win_p[i]   <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cell_in.valid) begin
            in_rho   <= cell_in.rho_in;
            in_u     <= cell_in.u_in;
            in_p     <= cell_in.p_in;
            in_last  <= cell_in.cell_last;
            err      <= 1'b0;
            had_pend <= pend_valid;
            pc       <= '0;
            if (pend_valid) state <= S_PEND;
            else if (cells_seen[1]) state <= S_READ;
            else state <= S_WIN;
          end
        end
        S_PEND: begin
          if (cell_out.ready) begin
            pend_valid <= 1'b0;
            state      <= cells_seen[1] ? S_READ : S_WIN;
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          unique case (cur.op)
            uecu_pkg::OP_MUL: begin
              mx    <= mag(opa);
              my    <= mag(opb);
              mneg  <= opa[A-1] ^ opb[A-1];
              mcnt  <= '0;
              acc   <= '0;
              state <= S_MUL;
            end
            uecu_pkg::OP_DIV: begin
              if (opb == '0) begin
                res   <= opa[A-1] ? uecu_pkg::W_MIN : uecu_pkg::W_MAX;
                err   <= 1'b1;
                state <= S_WB;
              end else begin
                dvd   <= {mag(opa), F'(0)};
                dden  <= mag(opb);
                rem   <= '0;
                quo   <= '0;
                dneg  <= opa[A-1] ^ opb[A-1];
                dcnt  <= '0;
                state <= S_DIV;
              end
            end
            default: begin
              res   <= alu_res;
              state <= S_WB;
            end
          endcase
        end
        S_MUL: begin
          // Register each partial product, then add it in place
          if (mcnt != 3'd4) pp <= prod;
          if (mcnt != 3'd0) begin
            unique case (mk)
              2'd0:       acc <= acc + {{A{1'b0}}, pp};
              2'd1, 2'd2: acc <= acc + {{H{1'b0}}, pp, {H{1'b0}}};
              default:    acc <= acc + {pp, {A{1'b0}}};
            endcase
          end
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd4) state <= S_MULF;
        end
        S_MULF: begin
          res   <= mulf_res;
          state <= S_WB;
        end
        S_DIV: begin
          rem  <= ge ? A'(rem2 - {1'b0, dden}) : A'(rem2);
          quo  <= {quo[D-2:0], ge};
          dvd  <= {dvd[D-2:0], 1'b0};
          dcnt <= dcnt + 1'b1;
          if (dcnt == uecu_pkg::DCNT_BITS'(D - 1)) state <= S_DIVF;
        end
        S_DIVF: begin
          res   <= divf_res;
          state <= S_WB;
        end
        S_WB: begin
          if (cur.dst == uecu_pkg::R_RN) rn <= res[W-1:0];
          if (cur.dst == uecu_pkg::R_UN) un <= res[W-1:0];
          if (cur.dst == uecu_pkg::R_PN) pn <= res[W-1:0];
          if (pc == uecu_pkg::PC_BITS'(uecu_pkg::PROG_LEN - 1))
            state <= (cells_seen == 2'd2) ? S_LB : S_MID;
          else begin
            pc    <= pc + 1'b1;
            state <= S_READ;
          end
        end
        S_LB: if (cell_out.ready) state <= S_MID;
        S_MID: begin
          if (cell_out.ready) begin
            if (in_last && !had_pend && cells_seen != 2'd2) state <= S_RB;
            else begin
              if (in_last) begin
                pend_valid <= 1'b1;
                pend_rho   <= rn;
                pend_p     <= pn;
              end
              state <= S_WIN;
            end
          end
        end
        S_RB: if (cell_out.ready) state <= S_WIN;
        S_WIN: begin
          // Advance the window and the fill count
          win_rho[0] <= win_rho[1];
          win_u[0]   <= win_u[1];
          win_p[0]   <= win_p[1];
          win_rho[1] <= in_rho;
          win_u[1]   <= in_u;
          win_p[1]   <= in_p;
          if (in_last) cells_seen <= '0;
          else if (cells_seen != 2'd3) cells_seen <= cells_seen + 2'd1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cell_in.ready |-> !cell_out.valid)
    else $error("input taken while an output beat is pending");

  a_boundary_beat: assert property (@(posedge clk) disable iff (rst)
    cell_out.valid && cell_out.last_out |-> cell_out.u_out == '0 && !cell_out.div_error)
    else $error("boundary beat carries velocity or error");

  a_div_error_sat: assert property (@(posedge clk) disable iff (rst)
    cell_out.valid && cell_out.div_error |->
      (sext(cell_out.u_out) == uecu_pkg::W_MAX || sext(cell_out.u_out) == uecu_pkg::W_MIN))
    else $error("zero density without saturated velocity");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> pc < uecu_pkg::PC_BITS'(uecu_pkg::PROG_LEN))
    else $error("micro-program counter out of range");

endmodule
